// ===== rtl/joystick_differential_drive_mixer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// joystick differential drive mixer assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_UNIT_ASSERT_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define JDDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JDDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define JDDM_ASSERT(lbl, prop, msg)
`define JDDM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/jddm_pkg.sv =====
// ----------------------------------------------------------------------------
// jddm_pkg
// widths, constants and shared types of the drive mixer
// ----------------------------------------------------------------------------
package jddm_pkg;

  localparam int STICK_W  = 8;
  localparam int ANGLE_W  = 8;
  localparam int MP_W     = 9;
  localparam int PT_W     = 4;
  localparam int RAMP_W   = 5;
  localparam int V_W      = 9;    // mixed motor value, signed
  localparam int MIX_W    = V_W + 1;
  localparam int MAG_W    = 8;    // magnitude of a motor value, up to 129
  localparam int K_W      = 14;   // power times register times boost, up to 15330
  localparam int OP_A_W   = 15;
  localparam int OP_B_W   = 16;
  localparam int PROD_W   = OP_A_W + OP_B_W;
  localparam int DQ_W     = 12;   // pre-shifted value before the divide by 5 or 25
  localparam int O_W      = 10;   // scaled value magnitude, up to 772
  localparam int SLOPE_W  = 16;

  // shifts for division by reciprocal multiplication
  localparam int PRE5     = 9;    // 2560 = 512 * 5
  localparam int PRE25    = 10;   // 25600 = 1024 * 25
  localparam int SH5      = 18;
  localparam int SH25     = 20;
  localparam int SH127    = 22;

  localparam logic [OP_B_W-1:0] RECIP5      = 16'd52429;
  localparam logic [OP_B_W-1:0] RECIP25     = 16'd41944;
  localparam logic [OP_B_W-1:0] RECIP127    = 16'd33027;
  localparam logic [OP_B_W-1:0] BOOST_MUL   = 16'd3;
  localparam logic [OP_B_W-1:0] UNIT_MUL    = 16'd1;
  localparam logic [OP_B_W-1:0] ANGLE_SLOPE = 16'd45;

  localparam logic [SLOPE_W-1:0] NEG_BASE = 16'd11430;  // 90 * 127
  localparam logic [SLOPE_W-1:0] POS_BASE = 16'd12700;  // 100 * 127
  localparam logic [OP_A_W-1:0]  X_MAX    = 15'd22860;  // 180 * 127

  localparam logic signed [MIX_W-1:0] STICK_CENTRE = 10'sd127;
  localparam logic signed [MIX_W-1:0] THR_MAX      = 10'sd127;
  localparam logic signed [MIX_W-1:0] DEADBAND     = 10'sd5;
  localparam logic signed [MIX_W-1:0] MIX_ONE      = 10'sd1;

  localparam logic [PT_W-1:0]   PT_FULL    = 4'd10;
  localparam logic [PT_W-1:0]   PT_INIT    = 4'd1;
  localparam logic [RAMP_W-1:0] RAMP_LIMIT = 5'd20;
  localparam logic [RAMP_W-1:0] RAMP_SAT   = 5'd21;
  localparam logic [MP_W-1:0]   MP_RESET   = 9'd256;

  localparam logic [ANGLE_W-1:0] ANGLE_STOP = 8'd93;
  localparam logic [ANGLE_W-1:0] ANGLE_MIN  = 8'd0;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX  = 8'd180;

  typedef struct packed {
    logic signed [V_W-1:0] rv;
    logic signed [V_W-1:0] lv;
    logic [PT_W-1:0]       pt;
    logic [RAMP_W-1:0]     ramp;
  } mix_t;

  typedef struct packed {
    logic              en;
    logic [OP_A_W-1:0] a;
    logic [OP_B_W-1:0] b;
  } mul_req_t;

endpackage

// ===== rtl/jddm_in_if.sv =====
// ----------------------------------------------------------------------------
// jddm_in_if
// input channel: stick bytes, link status and boost buttons
// ----------------------------------------------------------------------------
interface jddm_in_if import jddm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STICK_W-1:0] throttle_stick;
  logic [STICK_W-1:0] steer_stick;
  logic               link_up;
  logic               boost_up;
  logic               boost_down;

  modport source (
    output valid, throttle_stick, steer_stick, link_up, boost_up, boost_down,
    input  ready
  );
  modport sink (
    input  valid, throttle_stick, steer_stick, link_up, boost_up, boost_down,
    output ready
  );
endinterface

// ===== rtl/jddm_out_if.sv =====
// ----------------------------------------------------------------------------
// jddm_out_if
// output channel: two servo angles and the halt flag
// ----------------------------------------------------------------------------
interface jddm_out_if import jddm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] right_angle;
  logic [ANGLE_W-1:0] left_angle;
  logic               halted;

  modport source (
    output valid, right_angle, left_angle, halted,
    input  ready
  );
  modport sink (
    input  valid, right_angle, left_angle, halted,
    output ready
  );
endinterface

// ===== rtl/joystick_differential_drive_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer_unit
// arcade drive mixer with power ramp, one shared multiplier under a sequencer
// ----------------------------------------------------------------------------
// One item is taken when in_i.ready is high, which is only while the
// sequencer is idle. A connected item runs ten products in series through the
// single multiplier (power times motor power, boost, then per motor the
// magnitude, a reciprocal divide, the angle slope and a reciprocal divide by
// 127), and the next item is taken only once its result has been pushed to
// the output register. A motor whose scaled value is zero or whose negative
// angle bottoms out at zero skips the last step. An item with the link down
// skips the arithmetic and goes straight to the push step, which yields both
// angles at 93 with halted set. The result is held in an output register
// until taken; a stalled output holds the sequencer at its last step.
// motor_power is to be written by the user through cfg_we_i and cfg_wdata_i
// only while the block is idle; the block itself does not enforce this.
// motor_power resets to 256.
`include "joystick_differential_drive_mixer_unit_assert.svh"

module joystick_differential_drive_mixer_unit import jddm_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [MP_W-1:0] cfg_wdata_i,
  jddm_in_if.sink         in_i,
  jddm_out_if.source      out_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_KPM,
    S_KBST,
    S_KCAP,
    S_MV,
    S_MQ,
    S_MO,
    S_MX,
    S_MA,
    S_PUSH
  } state_e;

  state_e             state_q;
  logic [PT_W-1:0]    pt_q;
  logic [RAMP_W-1:0]  ramp_q;
  logic [MP_W-1:0]    mp_q;
  logic               mot_q;
  logic [MAG_W-1:0]   mag_q [2];
  logic               neg_q [2];
  logic [ANGLE_W-1:0] ang_q [2];
  logic               halt_q;
  logic               bst_q;
  logic               dn_q;
  logic               oz_q;
  logic [K_W-1:0]     k_q;
  logic               out_valid_q;
  logic [ANGLE_W-1:0] out_r_q;
  logic [ANGLE_W-1:0] out_l_q;
  logic               out_h_q;

  logic               in_fire;
  mix_t               mix;
  mul_req_t           mul_req;
  logic [PROD_W-1:0]  prod;
  logic [O_W-1:0]     o_w;
  logic [SLOPE_W-1:0] slope;
  logic [SLOPE_W:0]   pos_sum;
  logic [SLOPE_W-1:0] neg_diff;
  logic               neg_zero;
  logic [OP_A_W-1:0]  x_w;
  logic [ANGLE_W-1:0] angle_w;
  logic [V_W-1:0]     rv_abs;
  logic [V_W-1:0]     lv_abs;

  assign in_fire      = in_i.valid & in_i.ready;
  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.right_angle = out_r_q;
  assign out_o.left_angle  = out_l_q;
  assign out_o.halted = out_h_q;

  jddm_mix u_mix (
    .throttle_stick_i (in_i.throttle_stick),
    .steer_stick_i    (in_i.steer_stick),
    .pt_i             (pt_q),
    .ramp_i           (ramp_q),
    .mix_o            (mix)
  );

  jddm_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  assign rv_abs = mix.rv[V_W-1] ? V_W'(-mix.rv) : V_W'(mix.rv);
  assign lv_abs = mix.lv[V_W-1] ? V_W'(-mix.lv) : V_W'(mix.lv);

  // angle arithmetic on the product of the previous step
  always_comb begin
    o_w      = dn_q ? prod[SH25 +: O_W] : prod[SH5 +: O_W];
    slope    = prod[SLOPE_W-1:0];
    pos_sum  = {1'b0, slope} + {1'b0, POS_BASE};
    neg_zero = slope > NEG_BASE;
    neg_diff = NEG_BASE - slope;
    if (neg_q[mot_q]) begin
      x_w = neg_diff[OP_A_W-1:0];
    end else if (pos_sum > (SLOPE_W + 1)'(X_MAX)) begin
      x_w = X_MAX;
    end else begin
      x_w = pos_sum[OP_A_W-1:0];
    end
    angle_w = prod[SH127 +: ANGLE_W];
  end

  always_comb begin
    mul_req = '0;
    case (state_q)
      S_KPM: begin
        mul_req.en = 1'b1;
        mul_req.a  = OP_A_W'(pt_q);
        mul_req.b  = OP_B_W'(mp_q);
      end
      S_KBST: begin
        mul_req.en = 1'b1;
        mul_req.a  = OP_A_W'(prod[K_W-1:0]);
        mul_req.b  = bst_q ? BOOST_MUL : UNIT_MUL;
      end
      S_MV: begin
        mul_req.en = 1'b1;
        mul_req.a  = OP_A_W'(k_q);
        mul_req.b  = OP_B_W'(mag_q[mot_q]);
      end
      S_MQ: begin
        // low boost divides by 25600, otherwise by 2560
        mul_req.en = 1'b1;
        mul_req.a  = dn_q ? OP_A_W'(prod[PRE25 +: DQ_W]) : OP_A_W'(prod[PRE5 +: DQ_W]);
        mul_req.b  = dn_q ? RECIP25 : RECIP5;
      end
      S_MO: begin
        mul_req.en = 1'b1;
        mul_req.a  = OP_A_W'(o_w);
        mul_req.b  = ANGLE_SLOPE;
      end
      S_MX: begin
        mul_req.en = 1'b1;
        mul_req.a  = x_w;
        mul_req.b  = RECIP127;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q <= MP_RESET;
    end else if (cfg_we_i) begin
      mp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pt_q        <= '0;
      ramp_q      <= '0;
      mot_q       <= 1'b0;
      mag_q[0]    <= '0;
      mag_q[1]    <= '0;
      neg_q[0]    <= 1'b0;
      neg_q[1]    <= 1'b0;
      ang_q[0]    <= '0;
      ang_q[1]    <= '0;
      halt_q      <= 1'b0;
      bst_q       <= 1'b0;
      dn_q        <= 1'b0;
      oz_q        <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_r_q     <= '0;
      out_l_q     <= '0;
      out_h_q     <= 1'b0;
    end else begin
      // the push step reloads the output register itself
      if (out_valid_q && out_o.ready && (state_q != S_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (!in_i.link_up) begin
              ang_q[0] <= ANGLE_STOP;
              ang_q[1] <= ANGLE_STOP;
              halt_q   <= 1'b1;
              state_q  <= S_PUSH;
            end else begin
              pt_q     <= mix.pt;
              ramp_q   <= mix.ramp;
              mag_q[0] <= rv_abs[MAG_W-1:0];
              mag_q[1] <= lv_abs[MAG_W-1:0];
              neg_q[0] <= mix.rv[V_W-1];
              neg_q[1] <= mix.lv[V_W-1];
              bst_q    <= in_i.boost_up | in_i.boost_down;
              dn_q     <= in_i.boost_down & ~in_i.boost_up;
              halt_q   <= 1'b0;
              mot_q    <= 1'b0;
              state_q  <= S_KPM;
            end
          end
        end
        S_KPM: begin
          state_q <= S_KBST;
        end
        S_KBST: begin
          state_q <= S_KCAP;
        end
        S_KCAP: begin
          k_q     <= prod[K_W-1:0];
          state_q <= S_MV;
        end
        S_MV: begin
          state_q <= S_MQ;
        end
        S_MQ: begin
          state_q <= S_MO;
        end
        S_MO: begin
          oz_q    <= (o_w == '0);
          state_q <= S_MX;
        end
        S_MX: begin
          if (oz_q || (neg_q[mot_q] && neg_zero)) begin
            ang_q[mot_q] <= oz_q ? ANGLE_STOP : ANGLE_MIN;
            mot_q        <= 1'b1;
            state_q      <= mot_q ? S_PUSH : S_MV;
          end else begin
            state_q <= S_MA;
          end
        end
        S_MA: begin
          ang_q[mot_q] <= angle_w;
          mot_q        <= 1'b1;
          state_q      <= mot_q ? S_PUSH : S_MV;
        end
        S_PUSH: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_r_q     <= ang_q[0];
            out_l_q     <= ang_q[1];
            out_h_q     <= halt_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `JDDM_ASSERT_ALWAYS(a_pt_range, (pt_q <= PT_FULL), "ramp power above full")
  `JDDM_ASSERT_ALWAYS(a_ramp_range, (ramp_q <= RAMP_SAT), "ramp count above saturation")
  `JDDM_ASSERT(a_halt_stop,
    (out_o.valid && out_o.halted) |->
      (out_o.right_angle == ANGLE_STOP && out_o.left_angle == ANGLE_STOP),
    "halted item without stop angles")
  `JDDM_ASSERT(a_link_down_state,
    (in_fire && !in_i.link_up) |=> ($stable(pt_q) && $stable(ramp_q)),
    "link down item changed ramp state")
  `JDDM_ASSERT(a_angle_max,
    out_o.valid |-> (out_o.right_angle <= ANGLE_MAX && out_o.left_angle <= ANGLE_MAX),
    "angle above limit")

endmodule

// ===== rtl/jddm_mix.sv =====
// ----------------------------------------------------------------------------
// jddm_mix
// stick centering, deadband, turn mixing and power ramp next state
// ----------------------------------------------------------------------------
module jddm_mix import jddm_pkg::*; (
  input  logic [STICK_W-1:0] throttle_stick_i,
  input  logic [STICK_W-1:0] steer_stick_i,
  input  logic [PT_W-1:0]    pt_i,
  input  logic [RAMP_W-1:0]  ramp_i,
  output mix_t               mix_o
);

  logic signed [MIX_W-1:0] r;
  logic signed [MIX_W-1:0] s;
  logic signed [MIX_W-1:0] rv;
  logic signed [MIX_W-1:0] lv;
  logic                    neg_turn;
  logic                    pos_turn;
  logic [PT_W-1:0]         pt;
  logic [RAMP_W-1:0]       ramp;

  always_comb begin
    r = $signed({2'b00, throttle_stick_i}) - STICK_CENTRE;
    s = $signed({2'b00, steer_stick_i}) - STICK_CENTRE;
    if (r > THR_MAX) begin
      r = THR_MAX;
    end else if (r > -DEADBAND && r < DEADBAND) begin
      r = '0;
    end
    neg_turn = s < -DEADBAND;
    pos_turn = s > DEADBAND;
    rv   = r;
    lv   = r;
    pt   = pt_i;
    ramp = ramp_i;

    if (r < 0) begin
      if (neg_turn) begin
        lv = r - s;
      end else if (pos_turn) begin
        rv = r + s - MIX_ONE;
      end
    end else if (r > 0) begin
      if (neg_turn) begin
        lv = r + s - MIX_ONE;
      end else if (pos_turn) begin
        rv = r - s;
      end
    end else begin
      // spin in place runs at full power
      if (neg_turn) begin
        lv = -s;
        rv = s;
        pt = PT_FULL;
      end else if (pos_turn) begin
        rv = s - MIX_ONE;
        lv = -(s + MIX_ONE);
        pt = PT_FULL;
      end
    end

    if (r != 0) begin
      if (ramp > RAMP_LIMIT && pt < PT_FULL) begin
        pt   = pt + 1'b1;
        ramp = '0;
      end
      if (ramp < RAMP_SAT) begin
        ramp = ramp + 1'b1;
      end
    end else if (!(neg_turn || pos_turn)) begin
      pt   = PT_INIT;
      ramp = '0;
    end

    mix_o.rv   = rv[V_W-1:0];
    mix_o.lv   = lv[V_W-1:0];
    mix_o.pt   = pt;
    mix_o.ramp = ramp;
  end

endmodule

// ===== rtl/jddm_mul.sv =====
// ----------------------------------------------------------------------------
// jddm_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module jddm_mul import jddm_pkg::*; (
  input  logic              clk_i,
  input  mul_req_t          req_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= PROD_W'(req_i.a) * PROD_W'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== verif/joystick_differential_drive_mixer_unit_test.sv =====
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer_unit_test
// drives stick items into the drive mixer and checks every servo command
// against a cycle-free predictor of the mixing, ramp and scaling arithmetic;
// directed corner items first, then random drive runs under several idling,
// stall and motor power settings
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer_unit_test;
  import jddm_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_LIMIT  = 100;

  typedef struct packed {
    logic [STICK_W-1:0] throttle;
    logic [STICK_W-1:0] steer;
    logic               link_up;
    logic               boost_up;
    logic               boost_down;
  } stick_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] right_angle;
    logic [ANGLE_W-1:0] left_angle;
    logic               halted;
  } servo_cmd_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [MP_W-1:0] cfg_wdata_i;

  jddm_in_if  in_if ();
  jddm_out_if out_if ();

  joystick_differential_drive_mixer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // predictor state
  logic [MP_W-1:0]   motor_power_q;
  logic [PT_W-1:0]   power_tenths_q;
  logic [RAMP_W-1:0] ramp_ticks_q;

  servo_cmd_t servo_pending_q[$];
  servo_cmd_t got_cmd;
  servo_cmd_t want_cmd;
  int         error_count;
  int         idle_pct;
  int         stall_pct;
  int         quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // value times power, register and boost over 2560 or 25600, truncated toward zero
  function automatic longint scale_drive(input int v, input bit up, input bit down);
    longint num;
    longint den;
    int     pt;
    int     mp;
    pt  = power_tenths_q;
    mp  = motor_power_q;
    num = longint'(v) * longint'(pt) * longint'(mp);
    den = 2560;
    if (up) begin
      num = num * 3;
    end else if (down) begin
      num = num * 3;
      den = 25600;
    end
    return num / den;
  endfunction

  function automatic logic [ANGLE_W-1:0] servo_angle(input longint o);
    longint x;
    if (o == 0) return ANGLE_STOP;
    if (o < 0) x = 90 * 127 + 45 * o;
    else x = 100 * 127 + 45 * o;
    if (x < 0) return ANGLE_MIN;
    x = x / 127;
    if (x > longint'(ANGLE_MAX)) x = ANGLE_MAX;
    return x[ANGLE_W-1:0];
  endfunction

  // returns the servo command of one item and, when the link is up, updates the ramp state
  function automatic servo_cmd_t predict_servo(input stick_item_t it);
    int         r;
    int         s;
    int         rv;
    int         lv;
    int         db;
    bit         turning;
    servo_cmd_t cmd;
    db = DEADBAND;
    r  = int'(it.throttle) - int'(STICK_CENTRE);
    s  = int'(it.steer) - int'(STICK_CENTRE);
    turning = (s < -db) || (s > db);
    if (!it.link_up) begin
      cmd.right_angle = ANGLE_STOP;
      cmd.left_angle  = ANGLE_STOP;
      cmd.halted      = 1'b1;
      return cmd;
    end
    if (r > int'(THR_MAX)) r = THR_MAX;
    else if (r > -db && r < db) r = 0;
    rv = r;
    lv = r;
    if (r < 0) begin
      if (s < -db) lv = lv - s;
      else if (s > db) rv = rv + s - 1;
    end else if (r > 0) begin
      if (s < -db) lv = lv + s - 1;
      else if (s > db) rv = rv - s;
    end else begin
      // spin in place runs at full power
      if (s < -db) begin
        lv = lv - s;
        rv = rv + s;
        power_tenths_q = PT_FULL;
      end else if (s > db) begin
        rv = rv + s - 1;
        lv = lv - (s + 1);
        power_tenths_q = PT_FULL;
      end
    end
    if (r != 0) begin
      if (ramp_ticks_q > RAMP_LIMIT && power_tenths_q < PT_FULL) begin
        power_tenths_q = power_tenths_q + 1'b1;
        ramp_ticks_q   = '0;
      end
      if (ramp_ticks_q < RAMP_SAT) ramp_ticks_q = ramp_ticks_q + 1'b1;
    end else if (!turning) begin
      power_tenths_q = PT_INIT;
      ramp_ticks_q   = '0;
    end
    cmd.right_angle = servo_angle(scale_drive(rv, it.boost_up, it.boost_down));
    cmd.left_angle  = servo_angle(scale_drive(lv, it.boost_up, it.boost_down));
    cmd.halted      = 1'b0;
    return cmd;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < PRINT_LIMIT) begin
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    end
    error_count++;
  endtask

  // receiver side
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_cmd = '{out_if.right_angle, out_if.left_angle, out_if.halted};
      if (servo_pending_q.size() == 0) begin
        report_mismatch("unexpected item, right_angle", got_cmd.right_angle, 0);
      end else begin
        want_cmd = servo_pending_q.pop_front();
        if (got_cmd.right_angle !== want_cmd.right_angle)
          report_mismatch("right_angle", got_cmd.right_angle, want_cmd.right_angle);
        if (got_cmd.left_angle !== want_cmd.left_angle)
          report_mismatch("left_angle", got_cmd.left_angle, want_cmd.left_angle);
        if (got_cmd.halted !== want_cmd.halted)
          report_mismatch("halted", got_cmd.halted, want_cmd.halted);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[joystick_differential_drive_mixer_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic send_item(input stick_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.throttle_stick <= it.throttle;
    in_if.steer_stick    <= it.steer;
    in_if.link_up        <= it.link_up;
    in_if.boost_up       <= it.boost_up;
    in_if.boost_down     <= it.boost_down;
    do @(posedge clk_i); while (!in_if.ready);
    servo_pending_q.push_back(predict_servo(it));
  endtask

  task automatic send_sticks(input int thr, input int steer, input bit link,
                             input bit up, input bit down);
    stick_item_t it;
    it = '{thr[STICK_W-1:0], steer[STICK_W-1:0], link, up, down};
    send_item(it);
  endtask

  // waits out every pending command, then holds the inputs idle as a drain margin
  task automatic drain_commands();
    in_if.valid <= 1'b0;
    while (servo_pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_motor_power(input logic [MP_W-1:0] value);
    drain_commands();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    motor_power_q = value;
  endtask

  // power is zero until the first ramp step, spin or idle tick
  task automatic test_reset_power();
    send_sticks(200, 127, 1, 0, 0);
    send_sticks(0, 60, 1, 0, 0);
    send_sticks(127, 127, 1, 0, 0);
    send_sticks(255, 127, 1, 0, 0);
  endtask

  task automatic test_field_extremes();
    send_sticks(0, 127, 1, 0, 0);
    send_sticks(255, 0, 1, 0, 0);
    send_sticks(255, 255, 1, 0, 0);
    send_sticks(0, 0, 1, 0, 0);
    send_sticks(0, 255, 1, 0, 0);
    // deadband edges of the throttle
    send_sticks(122, 127, 1, 0, 0);
    send_sticks(123, 127, 1, 0, 0);
    send_sticks(131, 127, 1, 0, 0);
    send_sticks(132, 127, 1, 0, 0);
    // deadband edges of the steering
    send_sticks(200, 121, 1, 0, 0);
    send_sticks(200, 122, 1, 0, 0);
    send_sticks(200, 132, 1, 0, 0);
    send_sticks(200, 133, 1, 0, 0);
    send_sticks(127, 0, 1, 0, 0);
    send_sticks(127, 255, 1, 0, 0);
    send_sticks(127, 121, 1, 0, 0);
    send_sticks(127, 133, 1, 0, 0);
  endtask

  task automatic test_link_and_boost();
    send_sticks(255, 255, 0, 1, 1);
    send_sticks(0, 0, 0, 0, 0);
    send_sticks(255, 127, 1, 1, 1);
    send_sticks(255, 127, 1, 1, 0);
    send_sticks(255, 127, 1, 0, 1);
    send_sticks(0, 200, 1, 0, 1);
  endtask

  // mostly long moving runs so the ramp climbs, broken by idle, spin and noise
  task automatic test_random_drive(input int n_items, input int idle, input int stall,
                                   input logic [MP_W-1:0] power);
    int sent;
    int kind;
    int burst;
    bit fwd;
    int thr;
    int steer;
    write_motor_power(power);
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 70) burst = $urandom_range(240, 10);
      else if (kind < 85) burst = $urandom_range(3, 1);
      else if (kind < 95) burst = $urandom_range(5, 1);
      else burst = $urandom_range(10, 1);
      if (burst > n_items - sent) burst = n_items - sent;
      fwd = $urandom_range(1);
      repeat (burst) begin
        if (kind < 70) begin
          thr   = fwd ? $urandom_range(255, 132) : $urandom_range(122, 0);
          steer = $urandom_range(1) ? $urandom_range(132, 122) : $urandom_range(255, 0);
          send_sticks(thr, steer, $urandom_range(99) >= 3,
                      $urandom_range(3) == 0, $urandom_range(3) == 0);
        end else if (kind < 85) begin
          send_sticks($urandom_range(131, 123), $urandom_range(132, 122), 1,
                      $urandom_range(1), $urandom_range(1));
        end else if (kind < 95) begin
          steer = $urandom_range(1) ? $urandom_range(121, 0) : $urandom_range(255, 133);
          send_sticks($urandom_range(131, 123), steer, 1,
                      $urandom_range(1), $urandom_range(1));
        end else begin
          send_sticks($urandom_range(255), $urandom_range(255), $urandom_range(1),
                      $urandom_range(1), $urandom_range(1));
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = '0;
    in_if.valid          = 1'b0;
    in_if.throttle_stick = '0;
    in_if.steer_stick    = '0;
    in_if.link_up        = 1'b0;
    in_if.boost_up       = 1'b0;
    in_if.boost_down     = 1'b0;
    out_if.ready         = 1'b0;
    motor_power_q        = MP_RESET;
    power_tenths_q       = '0;
    ramp_ticks_q         = '0;
    error_count          = 0;
    idle_pct             = 0;
    stall_pct            = 0;
    quiet_cycles         = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_power();
    test_field_extremes();
    test_link_and_boost();
    test_random_drive(250, 0, 0, 9'd64);
    test_random_drive(130, 57, 0, 9'd511);
    test_random_drive(130, 0, 57, 9'd0);
    test_random_drive(130, 34, 34, 9'd90);
    test_random_drive(110, 0, 0, 9'($urandom_range(510, 1)));
    drain_commands();
    if (error_count == 0) begin
      $display("[joystick_differential_drive_mixer_unit] OK");
    end else begin
      $display("[joystick_differential_drive_mixer_unit] ERROR");
    end
    $finish;
  end

endmodule
